// ===== rtl/i2cmbe_pkg.sv =====
// Shared types and constants of the I2C master byte engine.
`timescale 1ns / 1ps

package i2cmbe_pkg;

    // Number of data bits in one byte transfer on the bus.
    localparam int unsigned BITS_PER_BYTE = 8;

    // Input item kinds, which double as the active operation codes.
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_IDLE     = 2'd1,
        ST_FINISHED = 2'd2,
        ST_REFUSED  = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic CFG_DELAY_TICKS = 1'b0;
    localparam logic CFG_LSB_FIRST   = 1'b1;

endpackage

// ===== rtl/i2c_master_byte_engine_core.sv =====
// Top level of the I2C master byte engine: command sequencer and open-drain line control.
`timescale 1ns / 1ps

// The engine takes one item per clock cycle while the result channel does not
// stall: a start, stop, write-byte or read-byte command, or a tick that
// advances the active command by one tick of its delay phase. Each item
// yields exactly one result, passing first through the input register and
// then through the state and result registers, and a new item can be taken
// in every cycle while results keep draining. The result carries the
// open-drain pin drive after the item was applied, the status, the last
// received byte and the acknowledge flag of the last write. Configuration
// writes are taken at any time and must be done while no item is in flight.
module i2c_master_byte_engine_core
(
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // Input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       sda_in,
    // Result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_drive_low,
    output logic       sda_drive_low,
    output logic [1:0] status,
    output logic [7:0] rx_byte,
    output logic       no_ack
);
    import i2cmbe_pkg::*;

    // Configuration registers
    logic [7:0] delay_ticks_reg;
    logic       lsb_first_reg;

    // Input register
    logic       in_q_valid_reg;
    logic [2:0] kind_q_reg;
    logic [7:0] data_q_reg;
    logic       sda_q_reg;

    // Engine state
    op_t        op_reg,        op_next;
    logic [1:0] phase_reg,     phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] delay_cnt_reg, delay_cnt_next;
    logic [7:0] shift_reg,     shift_next;
    logic       scl_low_reg,   scl_low_next;
    logic       sda_low_reg,   sda_low_next;
    logic       nack_reg,      nack_next;
    logic [7:0] rx_hold_reg,   rx_hold_next;

    // Result register
    logic       out_valid_reg;
    status_t    status_reg,    status_next;

    logic       out_ready;
    logic       fire;
    logic       in_xfer;
    logic       is_cmd;
    logic       ack_slot;
    logic [2:0] bit_idx;
    logic [7:0] limit;
    logic [7:0] delay_inc;
    logic       phase_end;
    logic       seq_done;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= 8'd1;
            lsb_first_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY_TICKS: delay_ticks_reg <= cfg_data;
                CFG_LSB_FIRST:   lsb_first_reg   <= cfg_data[0];
                default:         delay_ticks_reg <= delay_ticks_reg;
            endcase
        end
    end

    // Handshake: the processing step runs when the result register is free or drains.
    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = in_q_valid_reg && out_ready;
    assign in_stall  = in_q_valid_reg && !out_ready;
    assign in_xfer   = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_q_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_q_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_q_reg <= kind;
            data_q_reg <= data_byte;
            sda_q_reg  <= sda_in;
        end
    end

    // Decode of the buffered item and the timing of the current phase.
    assign is_cmd    = (kind_q_reg >= 3'(OP_START)) && (kind_q_reg <= 3'(OP_READ));
    assign ack_slot  = bit_count_reg[3];
    assign bit_idx   = lsb_first_reg ? bit_count_reg[2:0] : ~bit_count_reg[2:0];
    assign limit     = (delay_ticks_reg == 8'd0) ? 8'd1 : delay_ticks_reg;
    assign delay_inc = delay_cnt_reg + 8'd1;
    assign phase_end = delay_inc >= limit;

    // Next state of the command sequencer.
    always_comb
    begin
        op_next        = op_reg;
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        delay_cnt_next = delay_cnt_reg;
        shift_next     = shift_reg;
        scl_low_next   = scl_low_reg;
        sda_low_next   = sda_low_reg;
        nack_next      = nack_reg;
        rx_hold_next   = rx_hold_reg;
        seq_done       = 1'b0;

        if (is_cmd)
        begin
            // A new command is taken only while idle.
            if (op_reg == OP_IDLE)
            begin
                op_next        = op_t'(kind_q_reg);
                phase_next     = 2'd0;
                bit_count_next = 4'd0;
                delay_cnt_next = 8'd0;
                unique case (op_t'(kind_q_reg))
                    OP_START:
                    begin
                        scl_low_next = 1'b0;
                        sda_low_next = 1'b0;
                    end
                    OP_STOP:  sda_low_next = 1'b1;
                    OP_WRITE: shift_next   = data_q_reg;
                    default:
                    begin
                        shift_next   = 8'd0;
                        sda_low_next = 1'b0;
                    end
                endcase
            end
        end
        else if (op_reg != OP_IDLE)
        begin
            delay_cnt_next = delay_inc;
            if (phase_end)
            begin
                delay_cnt_next = 8'd0;
                unique case (op_reg)
                    OP_START:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            sda_low_next = 1'b1;
                            phase_next   = 2'd1;
                        end
                        else
                        begin
                            scl_low_next = 1'b1;
                            seq_done     = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_low_next = 1'b0;
                            phase_next   = 2'd1;
                        end
                        else
                        begin
                            sda_low_next = 1'b0;
                            seq_done     = 1'b1;
                        end
                    end
                    OP_WRITE, OP_READ:
                    begin
                        phase_next = phase_reg + 2'd1;
                        unique case (phase_reg)
                            2'd0:
                            begin
                                // Drive the data bit, or set up the acknowledge slot.
                                if (ack_slot)
                                    sda_low_next = (op_reg == OP_READ);
                                else if (op_reg == OP_WRITE)
                                    sda_low_next = !shift_reg[bit_idx];
                            end
                            2'd1: scl_low_next = 1'b0;
                            2'd2:
                            begin
                                // Sample SDA while SCL is high.
                                if (op_reg == OP_WRITE)
                                begin
                                    if (ack_slot)
                                        nack_next = sda_q_reg;
                                end
                                else if (!ack_slot && sda_q_reg)
                                begin
                                    shift_next[bit_idx] = 1'b1;
                                end
                            end
                            default:
                            begin
                                scl_low_next = 1'b1;
                                if (ack_slot)
                                begin
                                    if (op_reg == OP_READ)
                                        rx_hold_next = shift_reg;
                                    seq_done = 1'b1;
                                end
                                else
                                begin
                                    bit_count_next = bit_count_reg + 4'd1;
                                end
                            end
                        endcase
                    end
                    default: seq_done = 1'b1;
                endcase
                if (seq_done)
                begin
                    op_next        = OP_IDLE;
                    phase_next     = 2'd0;
                    bit_count_next = 4'd0;
                end
            end
        end
    end

    // Status of the result.
    always_comb
    begin
        if (is_cmd)
            status_next = (op_reg != OP_IDLE) ? ST_REFUSED : ST_BUSY;
        else if (op_reg == OP_IDLE)
            status_next = ST_IDLE;
        else if (seq_done)
            status_next = ST_FINISHED;
        else
            status_next = ST_BUSY;
    end

    // State and result registers advance together, once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_IDLE;
            phase_reg     <= 2'd0;
            bit_count_reg <= 4'd0;
            delay_cnt_reg <= 8'd0;
            shift_reg     <= 8'd0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            nack_reg      <= 1'b0;
            rx_hold_reg   <= 8'd0;
            status_reg    <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                op_reg        <= op_next;
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                delay_cnt_reg <= delay_cnt_next;
                shift_reg     <= shift_next;
                scl_low_reg   <= scl_low_next;
                sda_low_reg   <= sda_low_next;
                nack_reg      <= nack_next;
                rx_hold_reg   <= rx_hold_next;
                status_reg    <= status_next;
            end
            if (out_ready)
                out_valid_reg <= fire;
        end
    end

    // Result outputs come straight from the state, which holds while a result waits.
    assign out_valid     = out_valid_reg;
    assign scl_drive_low = scl_low_reg;
    assign sda_drive_low = sda_low_reg;
    assign status        = status_reg;
    assign rx_byte       = rx_hold_reg;
    assign no_ack        = nack_reg;

    // An idle sequencer has its bit position cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == OP_IDLE) |-> (phase_reg == 2'd0 && bit_count_reg == 4'd0))
        else $error("idle sequencer holds a stale bit position");

    // The bit counter never passes the acknowledge slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'(BITS_PER_BYTE))
        else $error("bit counter beyond acknowledge slot");

    // A finished status is reported only with the sequencer back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FINISHED) |-> (op_reg == OP_IDLE))
        else $error("finished status while a command is active");

    // A refused command leaves the active operation in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_cmd && op_reg != OP_IDLE) |=> (op_reg == $past(op_reg)))
        else $error("refused command altered the active operation");

    // A stalled result blocks the processing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(status_reg) && $stable(rx_hold_reg))
        else $error("result changed while stalled");

endmodule
